### rtl/bft_pkg.sv
// Package with the shared types, constants and key helpers of the flow table.
package bft_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = 48;
    localparam int ADDR_BYTES  = ADDR_W / 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PORT_W      = 16;
    localparam int PAIR_W      = 2 * PORT_W + 1;
    localparam int STREAM_W    = 10;
    localparam int PIDX_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORTS_EN   = 2'd1;

    localparam logic [2:0] ADDR_BYTES_RST = 3'd4;

    typedef enum logic [1:0] {
        OUT_HIT  = 2'd0,
        OUT_NEW  = 2'd1,
        OUT_REV  = 2'd2,
        OUT_FULL = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [PIDX_W-1:0] packet_index;
        logic [ADDR_W-1:0] src_address;
        logic [ADDR_W-1:0] dst_address;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic              port_present;
    } t_pkt;

    typedef struct packed {
        logic signed [STREAM_W-1:0] stream_id;
        t_outcome                   outcome;
    } t_res;

    typedef struct packed {
        logic [ADDR_W-1:0]   src;
        logic [ADDR_W-1:0]   dst;
        logic [PAIR_W-1:0]   port_pair;
        logic [STREAM_W-1:0] stream;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rd;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

    function automatic logic [ADDR_W-1:0] addr_mask(input logic [2:0] bytes);
        logic [ADDR_W-1:0] mask;
        mask = '0;
        for (int k = 0; k < ADDR_BYTES; k++) begin
            mask[k*8 +: 8] = (k < int'(bytes)) ? 8'hFF : 8'h00;
        end
        return mask;
    endfunction

endpackage

### rtl/bft_if.sv
// Channel interfaces for packets, results and configuration writes.
interface bft_pkt_if;
    logic          valid;
    logic          ready;
    bft_pkg::t_pkt data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bft_res_if;
    logic          valid;
    logic          ready;
    bft_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bft_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bft_pkg::CFG_IDX_W-1:0]    index;
    logic [bft_pkg::CFG_DATA_W-1:0]   wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/bft_ctrl.sv
// Controller state machine that sequences accept, table scan and decision.
module bft_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bft_pkg::t_sts i_sts,
    output bft_pkg::t_cmd o_cmd
);

    bft_pkg::t_state r_state;
    bft_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bft_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            bft_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bft_pkg::ST_SCAN;
                end
            end
            bft_pkg::ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = bft_pkg::ST_DRAIN;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            bft_pkg::ST_DRAIN: begin
                n_state = bft_pkg::ST_DECIDE;
            end
            bft_pkg::ST_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = bft_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bft_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/bft_dp.sv
// Datapath with configuration, key registers, entry memory, compare and result register.
module bft_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bft_pkg::t_pkt i_pkt_data,
    bft_cfg_if.sink       i_cfg,
    bft_res_if.source     o_res,
    input  bft_pkg::t_cmd i_cmd,
    output bft_pkg::t_sts o_sts
);

    logic [2:0]                     r_addr_bytes;
    logic                           r_ports_en;
    logic [bft_pkg::ADDR_W-1:0]     r_key_src;
    logic [bft_pkg::ADDR_W-1:0]     r_key_dst;
    logic [bft_pkg::PAIR_W-1:0]     r_fwd_pair;
    logic [bft_pkg::PAIR_W-1:0]     r_rev_pair;
    logic [bft_pkg::CNT_W-1:0]      r_count;
    logic [bft_pkg::CNT_W-1:0]      r_next;
    logic [bft_pkg::CNT_W-1:0]      r_addr;
    logic                           r_rd_vld;
    bft_pkg::t_entry                r_rd_data;
    bft_pkg::t_entry                r_mem [bft_pkg::TABLE_DEPTH];
    logic                           r_hit;
    logic                           r_rev;
    logic [bft_pkg::STREAM_W-1:0]   r_hit_stream;
    logic [bft_pkg::STREAM_W-1:0]   r_rev_stream;
    logic                           r_out_vld;
    bft_pkg::t_res                  r_out;
    bft_pkg::t_res                  n_out;
    bft_pkg::t_entry                n_entry;
    logic [bft_pkg::ADDR_W-1:0]     mask;
    logic                           use_ports;
    logic                           fwd_match;
    logic                           rev_match;
    logic                           full;
    logic                           wr_en;

    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    assign o_sts.scan_done = (r_addr == r_count);
    assign o_sts.out_free  = !r_out_vld || o_res.ready;

    assign mask      = bft_pkg::addr_mask(r_addr_bytes);
    assign use_ports = i_pkt_data.port_present && r_ports_en;

    assign fwd_match = r_rd_vld && (r_rd_data.src == r_key_src)
                       && (r_rd_data.dst == r_key_dst) && (r_rd_data.port_pair == r_fwd_pair);
    assign rev_match = r_rd_vld && (r_rd_data.src == r_key_dst)
                       && (r_rd_data.dst == r_key_src) && (r_rd_data.port_pair == r_rev_pair);

    assign full = (r_count == bft_pkg::CNT_W'(bft_pkg::TABLE_DEPTH));

    always_comb begin
        wr_en = 1'b0;
        if (r_hit) begin
            n_out.stream_id = r_hit_stream;
            n_out.outcome   = bft_pkg::OUT_HIT;
        end else if (full) begin
            n_out.stream_id = '0;
            n_out.outcome   = bft_pkg::OUT_FULL;
        end else if (r_rev) begin
            n_out.stream_id = -$signed(r_rev_stream);
            n_out.outcome   = bft_pkg::OUT_REV;
            wr_en           = i_cmd.decide;
        end else begin
            n_out.stream_id = bft_pkg::STREAM_W'(r_next);
            n_out.outcome   = bft_pkg::OUT_NEW;
            wr_en           = i_cmd.decide;
        end
        n_entry.src       = r_key_src;
        n_entry.dst       = r_key_dst;
        n_entry.port_pair = r_fwd_pair;
        n_entry.stream    = n_out.stream_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_bytes <= bft_pkg::ADDR_BYTES_RST;
            r_ports_en   <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bft_pkg::CFG_ADDR_BYTES: r_addr_bytes <= i_cfg.wdata;
                bft_pkg::CFG_PORTS_EN:   r_ports_en   <= i_cfg.wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_src <= i_pkt_data.src_address & mask;
            r_key_dst <= i_pkt_data.dst_address & mask;
            r_fwd_pair <= use_ports ? {1'b1, i_pkt_data.src_port, i_pkt_data.dst_port} : '0;
            r_rev_pair <= use_ports ? {1'b1, i_pkt_data.dst_port, i_pkt_data.src_port} : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_next   <= bft_pkg::CNT_W'(1);
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_rev    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.load) begin
                r_addr <= '0;
                r_hit  <= 1'b0;
                r_rev  <= 1'b0;
                if (i_pkt_data.packet_index == '0) begin
                    r_count <= '0;
                    r_next  <= bft_pkg::CNT_W'(1);
                end
            end else begin
                if (i_cmd.rd) begin
                    r_addr <= r_addr + bft_pkg::CNT_W'(1);
                end
                if (fwd_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (rev_match && !r_rev) begin
                    r_rev <= 1'b1;
                end
            end
            if (wr_en) begin
                r_count <= r_count + bft_pkg::CNT_W'(1);
                if (!r_rev) begin
                    r_next <= r_next + bft_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd_match && !r_hit) begin
            r_hit_stream <= r_rd_data.stream;
        end
        if (rev_match && !r_rev) begin
            r_rev_stream <= r_rd_data.stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[bft_pkg::IDX_W-1:0]] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_addr[bft_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.decide) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_out <= n_out;
        end
    end

endmodule

### rtl/bidirectional_flow_table.sv
// Top level of the bidirectional flow table.
//
//   Port      Direction  Transaction
//   i_pkt     sink       one packet with addresses, ports and packet index
//   o_res     source     one result: signed stream id and outcome
//   i_cfg     sink       one register write, index 0 address bytes, 1 ports enable
//
// A packet passes from acceptance through the scan, drain and decide states to the result.
// The next packet can be accepted in the cycle after the result is decided.
// The scan reads one table entry per cycle from the entry memory.
// Reset is synchronous and active low; it empties the table and restores the configuration and state registers.
// A new packet is accepted while the previous result still waits in the output register.
// A stalled output holds the decision until the register frees up.
module bidirectional_flow_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bft_pkt_if.sink   i_pkt,
    bft_res_if.source o_res,
    bft_cfg_if.sink   i_cfg
);

    bft_pkg::t_cmd cmd;
    bft_pkg::t_sts sts;

    bft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pkt.valid),
        .o_in_ready (i_pkt.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bft_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt_data (i_pkt.data),
        .i_cfg      (i_cfg),
        .o_res      (o_res),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

### rtl/bft_chk.sv
// Port-level checker for the flow table, bound to the top level.
module bft_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [bft_pkg::STREAM_W-1:0] i_stream_id,
    input bft_pkg::t_outcome                  i_outcome
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_stream_id)
        && $stable(i_outcome))
        else $error("Result changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Packet accepted during a running scan.");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_outcome == bft_pkg::OUT_FULL) |-> (i_stream_id == '0))
        else $error("Full outcome with nonzero stream id.");

    a_new_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_outcome == bft_pkg::OUT_NEW) |-> (i_stream_id > 0))
        else $error("New forward stream without a positive id.");

    a_rev_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_outcome == bft_pkg::OUT_REV) |-> (i_stream_id < 0))
        else $error("New reverse entry without a negative id.");

endmodule

bind bidirectional_flow_table bft_chk u_bft_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pkt.valid),
    .i_in_ready  (i_pkt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_stream_id (o_res.data.stream_id),
    .i_outcome   (o_res.data.outcome)
);
